### hw/rtl/stag_pkg.sv
// Shared types, codes and shape/size decode for the sprite texel address generator.
`default_nettype none

package stag_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_MAP_1D         = 2'd0,
		CFG_BOUNDARY_SHIFT = 2'd1,
		CFG_ACTIVE_WIDTH   = 2'd2,
		CFG_ACTIVE_HEIGHT  = 2'd3
	} cfg_reg_t;

	// Object mode field of attribute zero
	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_BLEND   = 2'd1,
		MODE_WINDOW  = 2'd2,
		MODE_BITMAP  = 2'd3
	} obj_mode_t;

	// Shape field of attribute zero
	typedef enum logic [1:0] {
		SHAPE_SQUARE     = 2'd0,
		SHAPE_WIDE       = 2'd1,
		SHAPE_TALL       = 2'd2,
		SHAPE_PROHIBITED = 2'd3
	} obj_shape_t;

	localparam int CfgDataWidth = 11;
	localparam logic [10:0] ActiveWidthReset  = 11'd256;
	localparam logic [9:0]  ActiveHeightReset = 10'd192;

	// Sprite dimensions as log2(size / 8): 0 = 8 px .. 3 = 64 px
	typedef struct packed {
		logic [1:0] lw;
		logic [1:0] lh;
	} obj_dim_t;

	function automatic obj_dim_t obj_dims(input obj_shape_t shape, input logic [1:0] size);
		obj_dim_t d;
		d.lw = size;
		d.lh = size;
		case (shape)
			SHAPE_SQUARE: begin
				d.lw = size;
				d.lh = size;
			end
			SHAPE_WIDE: begin
				case (size)
					2'd0:    begin d.lw = 2'd1; d.lh = 2'd0; end
					2'd1:    begin d.lw = 2'd2; d.lh = 2'd0; end
					2'd2:    begin d.lw = 2'd2; d.lh = 2'd1; end
					default: begin d.lw = 2'd3; d.lh = 2'd2; end
				endcase
			end
			SHAPE_TALL: begin
				case (size)
					2'd0:    begin d.lw = 2'd0; d.lh = 2'd1; end
					2'd1:    begin d.lw = 2'd0; d.lh = 2'd2; end
					2'd2:    begin d.lw = 2'd1; d.lh = 2'd2; end
					default: begin d.lw = 2'd2; d.lh = 2'd3; end
				endcase
			end
			default: begin
				d.lw = 2'd0;
				d.lh = 2'd0;
			end
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/stag_in_if.sv
// Input channel: one sprite pixel request per transaction.
`default_nettype none

interface stag_in_if;
	logic               valid;
	logic               ready;
	logic        [15:0] attr_zero;
	logic        [15:0] attr_one;
	logic        [15:0] attr_two;
	logic signed [15:0] mat_a;
	logic signed [15:0] mat_b;
	logic signed [15:0] mat_c;
	logic signed [15:0] mat_d;
	logic        [6:0]  box_x;
	logic        [6:0]  box_y;

	modport source (
		output valid, attr_zero, attr_one, attr_two, mat_a, mat_b, mat_c, mat_d, box_x, box_y,
		input  ready
	);
	modport sink (
		input  valid, attr_zero, attr_one, attr_two, mat_a, mat_b, mat_c, mat_d, box_x, box_y,
		output ready
	);
endinterface

`default_nettype wire

### hw/rtl/stag_out_if.sv
// Output channel: one texel address result per transaction.
`default_nettype none

interface stag_out_if;
	logic        valid;
	logic        ready;
	logic        draw_pixel;
	logic [9:0]  screen_x;
	logic [9:0]  screen_y;
	logic [18:0] cell_offset;
	logic        high_nibble;
	logic [3:0]  palette_bank;
	logic        color_256;

	modport source (
		output valid, draw_pixel, screen_x, screen_y, cell_offset, high_nibble, palette_bank,
		       color_256,
		input  ready
	);
	modport sink (
		input  valid, draw_pixel, screen_x, screen_y, cell_offset, high_nibble, palette_bank,
		       color_256,
		output ready
	);
endinterface

`default_nettype wire

### hw/rtl/sprite_texel_address_generator.sv
// Top level: four-stage sprite texel address pipeline with its configuration registers.
// Throughput: one pixel per cycle while the output is not stalled.
// Each stage holds one pixel; a stage loads whenever it is empty or the next one moves, so
// bubbles are squeezed out and a stalled output holds without loss or repeat.
// Reset (arst_n low): all stage valids clear, config returns to 2D map, boundary 0, 256x192.
// Data registers are not reset.
`default_nettype none

module sprite_texel_address_generator
	import stag_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [1:0]              cfg_index,
	input  wire logic [CfgDataWidth-1:0] cfg_data,
	stag_in_if.sink                      pix_in,
	stag_out_if.source                   pix_out
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic        map_1d_q;
	logic [1:0]  boundary_shift_q;
	logic [10:0] active_width_q;
	logic [9:0]  active_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_1d_q         <= 1'b0;
			boundary_shift_q <= 2'd0;
			active_width_q   <= ActiveWidthReset;
			active_height_q  <= ActiveHeightReset;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_MAP_1D:         map_1d_q         <= cfg_data[0];
				CFG_BOUNDARY_SHIFT: boundary_shift_q <= cfg_data[1:0];
				CFG_ACTIVE_WIDTH:   active_width_q   <= cfg_data[10:0];
				CFG_ACTIVE_HEIGHT:  active_height_q  <= cfg_data[9:0];
				default:            ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage advance: a stage loads when empty or when its successor loads.
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en1, en2, en3, en4;

	assign en4 = !valid_s4 || pix_out.ready;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign pix_in.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= pix_in.valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: attribute decode, box check, X/Y wrap, screen position,
	// position relative to the box centre.
	// ------------------------------------------------------------------
	logic       in_affine, in_double, in_c256, in_disabled, in_bad_mode, in_bad_shape;
	obj_dim_t   in_dim;
	logic [6:0] in_w;
	logic [7:0] in_bw, in_bh;
	logic [6:0] in_half_bw, in_half_bh;
	logic       in_outside_box;
	logic [7:0] in_y8;
	logic       in_ywrap;
	logic signed [9:0]  in_x, in_y;
	logic signed [10:0] in_px, in_py;
	logic signed [7:0]  in_cx, in_cy;

	assign in_affine    = pix_in.attr_zero[8];
	assign in_double    = pix_in.attr_zero[9] && in_affine;
	assign in_c256      = pix_in.attr_zero[13];
	assign in_disabled  = pix_in.attr_zero[9] && !in_affine;
	assign in_bad_mode  = (obj_mode_t'(pix_in.attr_zero[11:10]) == MODE_WINDOW) ||
	                      (obj_mode_t'(pix_in.attr_zero[11:10]) == MODE_BITMAP);
	assign in_bad_shape = obj_shape_t'(pix_in.attr_zero[15:14]) == SHAPE_PROHIBITED;
	assign in_dim       = obj_dims(obj_shape_t'(pix_in.attr_zero[15:14]), pix_in.attr_one[15:14]);

	assign in_w       = 7'd8 << in_dim.lw;
	assign in_bw      = {1'b0, in_w} << in_double;
	assign in_bh      = {1'b0, 7'd8 << in_dim.lh} << in_double;
	assign in_half_bw = in_bw[7:1];
	assign in_half_bh = in_bh[7:1];
	assign in_outside_box = ({1'b0, pix_in.box_x} >= in_bw) || ({1'b0, pix_in.box_y} >= in_bh);

	// X of 256 or more means X - 512: the 9-bit field read as signed
	assign in_x = $signed({pix_in.attr_one[8], pix_in.attr_one[8:0]});
	// Y of 192 or more wraps when the box would otherwise run past the bottom of the 256-line range
	assign in_y8    = pix_in.attr_zero[7:0];
	assign in_ywrap = (in_y8 >= 8'd192) && (({1'b0, in_y8} + {1'b0, in_bh}) >= 9'd256);
	assign in_y     = in_ywrap ? $signed({2'b11, in_y8}) : $signed({2'b00, in_y8});

	assign in_px = $signed({in_x[9], in_x}) + $signed({4'b0000, pix_in.box_x});
	assign in_py = $signed({in_y[9], in_y}) + $signed({4'b0000, pix_in.box_y});
	assign in_cx = $signed({1'b0, pix_in.box_x}) - $signed({1'b0, in_half_bw});
	assign in_cy = $signed({1'b0, pix_in.box_y}) - $signed({1'b0, in_half_bh});

	logic        draw_s1, affine_s1, c256_s1, hflip_s1, vflip_s1;
	logic [1:0]  lw_s1, lh_s1;
	logic signed [10:0] px_s1, py_s1;
	logic signed [7:0]  cx_s1, cy_s1;
	logic [5:0]  sx_s1, sy_s1;
	logic signed [15:0] mat_a_s1, mat_b_s1, mat_c_s1, mat_d_s1;
	logic [9:0]  tile_s1;
	logic [3:0]  pal_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			draw_s1   <= !(in_disabled || in_bad_mode || in_bad_shape || in_outside_box);
			affine_s1 <= in_affine;
			c256_s1   <= in_c256;
			hflip_s1  <= pix_in.attr_one[12];
			vflip_s1  <= pix_in.attr_one[13];
			lw_s1     <= in_dim.lw;
			lh_s1     <= in_dim.lh;
			px_s1     <= in_px;
			py_s1     <= in_py;
			cx_s1     <= in_cx;
			cy_s1     <= in_cy;
			sx_s1     <= pix_in.box_x[5:0];
			sy_s1     <= pix_in.box_y[5:0];
			mat_a_s1  <= pix_in.mat_a;
			mat_b_s1  <= pix_in.mat_b;
			mat_c_s1  <= pix_in.mat_c;
			mat_d_s1  <= pix_in.mat_d;
			tile_s1   <= pix_in.attr_two[9:0];
			pal_s1    <= pix_in.attr_two[15:12];
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: affine partial products, screen clipping.
	// ------------------------------------------------------------------
	logic on_screen_s1;
	assign on_screen_s1 = !px_s1[10] && !py_s1[10] &&
	                      ({1'b0, px_s1[9:0]} < active_width_q) &&
	                      (py_s1[9:0] < active_height_q);

	logic        draw_s2, affine_s2, c256_s2, hflip_s2, vflip_s2;
	logic [1:0]  lw_s2, lh_s2;
	logic [9:0]  px_s2, py_s2;
	logic [5:0]  sx_s2, sy_s2;
	logic signed [23:0] prod_a_s2, prod_b_s2, prod_c_s2, prod_d_s2;
	logic [9:0]  tile_s2;
	logic [3:0]  pal_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			draw_s2   <= draw_s1 && on_screen_s1;
			affine_s2 <= affine_s1;
			c256_s2   <= c256_s1;
			hflip_s2  <= hflip_s1;
			vflip_s2  <= vflip_s1;
			lw_s2     <= lw_s1;
			lh_s2     <= lh_s1;
			px_s2     <= px_s1[9:0];
			py_s2     <= py_s1[9:0];
			sx_s2     <= sx_s1;
			sy_s2     <= sy_s1;
			prod_a_s2 <= mat_a_s1 * cx_s1;
			prod_b_s2 <= mat_b_s1 * cy_s1;
			prod_c_s2 <= mat_c_s1 * cx_s1;
			prod_d_s2 <= mat_d_s1 * cy_s1;
			tile_s2   <= tile_s1;
			pal_s2    <= pal_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: matrix sums, floor shift, recentre and clip; flips for
	// plain sprites.
	// ------------------------------------------------------------------
	logic [6:0] w_s2, h_s2;
	logic signed [24:0] sum_x_s2, sum_y_s2;
	logic signed [17:0] aff_tx_s2, aff_ty_s2;
	logic       clip_s2;
	logic [5:0] tx_s2, ty_s2;

	assign w_s2 = 7'd8 << lw_s2;
	assign h_s2 = 7'd8 << lh_s2;
	assign sum_x_s2 = 25'(prod_a_s2) + 25'(prod_b_s2);
	assign sum_y_s2 = 25'(prod_c_s2) + 25'(prod_d_s2);
	// arithmetic shift gives floor rounding
	assign aff_tx_s2 = 18'(sum_x_s2 >>> 8) + $signed({12'd0, w_s2[6:1]});
	assign aff_ty_s2 = 18'(sum_y_s2 >>> 8) + $signed({12'd0, h_s2[6:1]});
	assign clip_s2 = aff_tx_s2[17] || (aff_tx_s2[16:0] >= {10'd0, w_s2}) ||
	                 aff_ty_s2[17] || (aff_ty_s2[16:0] >= {10'd0, h_s2});

	always_comb begin
		if (affine_s2) begin
			tx_s2 = aff_tx_s2[5:0];
			ty_s2 = aff_ty_s2[5:0];
		end else begin
			tx_s2 = hflip_s2 ? 6'(w_s2 - 7'd1 - {1'b0, sx_s2}) : sx_s2;
			ty_s2 = vflip_s2 ? 6'(h_s2 - 7'd1 - {1'b0, sy_s2}) : sy_s2;
		end
	end

	logic        draw_s3, c256_s3;
	logic [1:0]  lw_s3;
	logic [9:0]  px_s3, py_s3;
	logic [5:0]  tx_s3, ty_s3;
	logic [9:0]  tile_s3;
	logic [3:0]  pal_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			draw_s3 <= draw_s2 && !(affine_s2 && clip_s2);
			c256_s3 <= c256_s2;
			lw_s3   <= lw_s2;
			px_s3   <= px_s2;
			py_s3   <= py_s2;
			tx_s3   <= tx_s2;
			ty_s3   <= ty_s2;
			tile_s3 <= tile_s2;
			pal_s3  <= pal_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4 (output register): tile slot, byte offset, nibble select.
	// Every field is zero for a pixel that is not drawn.
	// ------------------------------------------------------------------
	logic [2:0]  tcol_s3, trow_s3, fx_s3, fy_s3;
	logic [6:0]  slot_1d_s3;
	logic [7:0]  slot_2d_s3, slot_s3;
	logic [18:0] tile_base_s3;
	logic [5:0]  byte_s3;
	logic [18:0] offset_s3;

	assign tcol_s3 = tx_s3[5:3];
	assign trow_s3 = ty_s3[5:3];
	assign fx_s3   = tx_s3[2:0];
	assign fy_s3   = ty_s3[2:0];

	// 1D: rows are w/8 tiles long, 256-colour tiles take two slots
	assign slot_1d_s3 = 7'(({3'd0, trow_s3} << lw_s3) + {3'd0, tcol_s3}) << c256_s3;
	// 2D: rows are 32 slots wide
	assign slot_2d_s3 = {trow_s3, 5'd0} + ({4'd0, tcol_s3} << c256_s3);
	assign slot_s3    = map_1d_q ? {1'b0, slot_1d_s3} : slot_2d_s3;

	assign tile_base_s3 = {4'd0, tile_s3, 5'd0} << boundary_shift_q;
	assign byte_s3      = c256_s3 ? {fy_s3, fx_s3} : {1'b0, fy_s3, fx_s3[2:1]};
	assign offset_s3    = tile_base_s3 + {6'd0, slot_s3, 5'd0} + {13'd0, byte_s3};

	logic        draw_s4, high_nibble_s4, c256_s4;
	logic [9:0]  px_s4, py_s4;
	logic [18:0] offset_s4;
	logic [3:0]  pal_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			draw_s4        <= draw_s3;
			px_s4          <= draw_s3 ? px_s3 : 10'd0;
			py_s4          <= draw_s3 ? py_s3 : 10'd0;
			offset_s4      <= draw_s3 ? offset_s3 : 19'd0;
			high_nibble_s4 <= draw_s3 && !c256_s3 && fx_s3[0];
			pal_s4         <= draw_s3 ? pal_s3 : 4'd0;
			c256_s4        <= draw_s3 && c256_s3;
		end
	end

	assign pix_out.valid        = valid_s4;
	assign pix_out.draw_pixel   = draw_s4;
	assign pix_out.screen_x     = px_s4;
	assign pix_out.screen_y     = py_s4;
	assign pix_out.cell_offset  = offset_s4;
	assign pix_out.high_nibble  = high_nibble_s4;
	assign pix_out.palette_bank = pal_s4;
	assign pix_out.color_256    = c256_s4;

endmodule

`default_nettype wire
